/* rtl/bole_pkg.sv */
// Package for the bounded ordered list engine.
// Holds field widths, command, status and cell operation codes and the cell command struct.
// Depends on nothing; every other file uses it.
`default_nettype none
package bole_pkg;

   localparam int CAPACITY  = 16;
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int CMD_W     = 2;
   localparam int DATA_W    = 32;
   localparam int POS_W     = 6;
   localparam int STATUS_W  = 3;
   localparam int LEN_W     = 7;
   localparam int WIDE_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND    = 2'd0,
      CMD_DEL_VALUE = 2'd1,
      CMD_DEL_POS   = 2'd2,
      CMD_DUMP      = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_RANGE     = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_APPEND,
      OP_ROTATE,
      OP_DROP
   } cell_op_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DUMP,
      S_SCAN
   } state_type;

   typedef struct packed {
      cell_op_type              op;
      logic signed [DATA_W-1:0] wr_value;
   } cell_cmd_type;

endpackage
`default_nettype wire

/* rtl/bole_req_if.sv */
// Request channel interface of the bounded ordered list engine.
// Carries valid, ready and the command payload; depends on bole_pkg.
`default_nettype none
interface bole_req_if;
   logic                                 valid;
   logic                                 ready;
   logic        [bole_pkg::CMD_W-1:0]    cmd;
   logic signed [bole_pkg::DATA_W-1:0]   item_value;
   logic        [bole_pkg::POS_W-1:0]    position;

   modport source (output valid, cmd, item_value, position, input ready);
   modport sink   (input valid, cmd, item_value, position, output ready);
endinterface
`default_nettype wire

/* rtl/bole_rsp_if.sv */
// Response channel interface of the bounded ordered list engine.
// Carries valid, ready and the result payload; depends on bole_pkg.
`default_nettype none
interface bole_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic        [bole_pkg::STATUS_W-1:0]  status;
   logic signed [bole_pkg::DATA_W-1:0]    entry_value;
   logic                                  last;
   logic        [bole_pkg::LEN_W-1:0]     length;

   modport source (output valid, status, entry_value, last, length, input ready);
   modport sink   (input valid, status, entry_value, last, length, output ready);
endinterface
`default_nettype wire

/* rtl/bounded_ordered_list_engine.sv */
// Top level of the bounded ordered list engine: sequencer plus a chain of list cells.
// Depends on bole_pkg, bole_req_if, bole_rsp_if, bole_cell and bole_ctrl.
//
// The list lives in a chain of CAPACITY cells with the head in the first cell. Append,
// and any command that ends in empty, full or out of range, is answered with one beat
// straight from the idle state, so such requests can follow one another every cycle
// while no beat is stalled. Delete by value or by position takes the request, then
// steps once per entry. A dump takes the request, then gives one beat per entry,
// one per cycle while no beat is stalled. In each step the chain rotates one entry
// past the head, where it is compared or sent out, and a deleted entry is simply not
// carried round. Results leave through a single output register. A beat waiting there
// stalls the dump or the final step of a delete, and the next request is taken in the
// cycle that the last beat of the current one leaves that register, or later.
`default_nettype none
module bounded_ordered_list_engine (
   input  wire logic   clock,
   input  wire logic   reset,
   bole_req_if.sink    req,
   bole_rsp_if.source  rsp
);
   import bole_pkg::*;

   cell_cmd_type             cell_cmd;
   logic [CNT_W-1:0]         count;
   logic [CAPACITY-1:0]      occ;
   logic [CAPACITY-1:0]      left_occ;
   logic [CAPACITY-1:0]      next_occ;
   logic signed [DATA_W-1:0] value      [CAPACITY];
   logic signed [DATA_W-1:0] next_value [CAPACITY];

   bole_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .rsp        (rsp),
      .head_value (value[0]),
      .cell_cmd   (cell_cmd),
      .count      (count)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign left_occ[i] = 1'b1;
      end else begin : g_body
         assign left_occ[i] = occ[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign next_occ[i]   = 1'b0;
         assign next_value[i] = '0;
      end else begin : g_link
         assign next_occ[i]   = occ[i+1];
         assign next_value[i] = value[i+1];
      end

      bole_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cell_cmd),
         .left_occ   (left_occ[i]),
         .next_occ   (next_occ[i]),
         .next_value (next_value[i]),
         .head_value (value[0]),
         .occ        (occ[i]),
         .value      (value[i])
      );
   end

   a_occ_matches_count: assert property (@(posedge clock) disable iff (reset)
      $countones(occ) == int'(count))
      else $error("cell occupancy disagrees with entry count");

   a_occ_contiguous: assert property (@(posedge clock) disable iff (reset)
      (occ & (occ + CAPACITY'(1))) == '0)
      else $error("occupied cells are not a contiguous run from the head");

   a_no_accept_while_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |-> !req.ready)
      else $error("request taken while a response beat is stalled");

   a_error_is_single_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status != ST_OK) |-> (rsp.last && rsp.entry_value == '0))
      else $error("error response is not a single final beat");
endmodule
`default_nettype wire

/* rtl/bole_cell.sv */
// One cell of the list chain: a stored entry and its occupancy bit.
// Cells talk only to their neighbours and to the broadcast command and head value; depends on bole_pkg.
`default_nettype none
module bole_cell (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire bole_pkg::cell_cmd_type              cmd,
   input  wire logic                                left_occ,
   input  wire logic                                next_occ,
   input  wire logic signed [bole_pkg::DATA_W-1:0]  next_value,
   input  wire logic signed [bole_pkg::DATA_W-1:0]  head_value,
   output logic                                     occ,
   output logic signed [bole_pkg::DATA_W-1:0]       value
);
   import bole_pkg::*;

   logic                     occ_ff, occ_in;
   logic signed [DATA_W-1:0] value_ff, value_in;

   always_comb begin
      occ_in   = occ_ff;
      value_in = value_ff;
      case (cmd.op)
         OP_APPEND: begin
            if (!occ_ff && left_occ) begin
               occ_in   = 1'b1;
               value_in = cmd.wr_value;
            end
         end
         OP_ROTATE: begin
            if (occ_ff) begin
               value_in = next_occ ? next_value : head_value;
            end
         end
         OP_DROP: begin
            occ_in   = occ_ff & next_occ;
            value_in = next_value;
         end
         default: begin
            occ_in   = occ_ff;
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign occ   = occ_ff;
   assign value = value_ff;
endmodule
`default_nettype wire

/* rtl/bole_ctrl.sv */
// Sequencer of the list engine: command decode, scan and dump stepping, entry count
// and the registered response stage. Depends on bole_pkg, bole_req_if and bole_rsp_if.
`default_nettype none
module bole_ctrl (
   input  wire logic                                clock,
   input  wire logic                                reset,
   bole_req_if.sink                                 req,
   bole_rsp_if.source                               rsp,
   input  wire logic signed [bole_pkg::DATA_W-1:0]  head_value,
   output bole_pkg::cell_cmd_type                   cell_cmd,
   output logic [bole_pkg::CNT_W-1:0]               count
);
   import bole_pkg::*;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         step_ff, step_in;
   logic [CNT_W-1:0]         limit_ff, limit_in;
   logic                     found_ff, found_in;
   logic signed [DATA_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0]         pos_ff, pos_in;
   cmd_type                  kind_ff, kind_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic [LEN_W-1:0]         rsp_len_ff, rsp_len_in;

   logic                     out_free;
   logic                     step_last;
   logic                     accept;
   logic                     hit;
   logic                     advance;
   logic                     load;
   cmd_type                  req_cmd;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign step_last = (step_ff == (limit_ff - CNT_W'(1)));
   assign req_cmd   = cmd_type'(req.cmd);
   assign accept    = (state_ff == S_IDLE) && req.valid && out_free;
   assign hit       = !found_ff && ((kind_ff == CMD_DEL_VALUE) ? (head_value == key_ff)
                                                               : (step_ff == pos_ff));
   assign advance   = !step_last || out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && (count_ff != '0)) begin
               if (req_cmd == CMD_DUMP) begin
                  state_in = S_DUMP;
               end else if (req_cmd == CMD_DEL_VALUE) begin
                  state_in = S_SCAN;
               end else if (req_cmd == CMD_DEL_POS &&
                            WIDE_W'(req.position) < WIDE_W'(count_ff)) begin
                  state_in = S_SCAN;
               end
            end
         end
         S_DUMP: begin
            if (out_free && step_last) begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (advance && step_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req.ready         = 1'b0;
      cell_cmd.op       = OP_HOLD;
      cell_cmd.wr_value = req.item_value;
      count_in          = count_ff;
      step_in           = step_ff;
      limit_in          = limit_ff;
      found_in          = found_ff;
      key_in            = key_ff;
      pos_in            = pos_ff;
      kind_in           = kind_ff;
      load              = 1'b0;
      rsp_status_in     = ST_OK;
      rsp_value_in      = '0;
      rsp_last_in       = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req.ready = out_free;
            if (accept) begin
               step_in  = '0;
               limit_in = count_ff;
               found_in = 1'b0;
               key_in   = req.item_value;
               pos_in   = CNT_W'(req.position);
               kind_in  = req_cmd;
               case (req_cmd)
                  CMD_APPEND: begin
                     load = 1'b1;
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        cell_cmd.op = OP_APPEND;
                        count_in    = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_DUMP: begin
                     if (count_ff == '0) begin
                        load          = 1'b1;
                        rsp_status_in = ST_EMPTY;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        load          = 1'b1;
                        rsp_status_in = ST_EMPTY;
                     end else if (req_cmd == CMD_DEL_POS &&
                                  WIDE_W'(req.position) >= WIDE_W'(count_ff)) begin
                        load          = 1'b1;
                        rsp_status_in = ST_RANGE;
                     end
                  end
               endcase
            end
         end
         S_DUMP: begin
            if (out_free) begin
               load         = 1'b1;
               rsp_value_in = head_value;
               rsp_last_in  = step_last;
               cell_cmd.op  = OP_ROTATE;
               step_in      = step_ff + CNT_W'(1);
            end
         end
         S_SCAN: begin
            if (advance) begin
               cell_cmd.op = hit ? OP_DROP : OP_ROTATE;
               step_in     = step_ff + CNT_W'(1);
               found_in    = found_ff | hit;
               if (hit) begin
                  count_in = count_ff - CNT_W'(1);
               end
               if (step_last) begin
                  load          = 1'b1;
                  rsp_status_in = found_in ? ST_OK : ST_NOT_FOUND;
               end
            end
         end
         default: begin
            req.ready = 1'b0;
         end
      endcase
   end

   assign rsp_len_in   = LEN_W'(count_in);
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      limit_ff <= limit_in;
      found_ff <= found_in;
      key_ff   <= key_in;
      pos_ff   <= pos_in;
      kind_ff  <= kind_in;
      if (load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_len_ff    <= rsp_len_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.entry_value = rsp_value_ff;
   assign rsp.last        = rsp_last_ff;
   assign rsp.length      = rsp_len_ff;
   assign count           = count_ff;
endmodule
`default_nettype wire
